>>> rtl/tamad_pkg.sv
// ----------------------------------------------------------------------------
// tamad_pkg: shared constants for the three-axis moving average unit
// Default sizes, register reset value and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tamad_pkg;

    localparam int WINDOW_LOG2_DEF = 5;   // 32-deep boxcar window
    localparam int SAMPLE_BITS_DEF = 13;  // signed sample width

    localparam int          THRESH_BITS  = 12;
    localparam logic [11:0] THRESH_RESET = 12'd2;

    // operation codes (carried on s_tuser)
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

endpackage

`default_nettype wire

>>> rtl/tamad_cell.sv
// ----------------------------------------------------------------------------
// tamad_cell: one window slot
// Holds one x/y/z sample and passes it to the next slot on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module tamad_cell
    import tamad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     shift_en,
    input  wire logic [3*SAMPLE_BITS-1:0] xyz_in,   // x, y, z from bit 0 up
    output logic      [3*SAMPLE_BITS-1:0] xyz_out
);

    logic [3*SAMPLE_BITS-1:0] xyz_reg;
    logic [3*SAMPLE_BITS-1:0] xyz_next;

    assign xyz_next = shift_en ? xyz_in : xyz_reg;

    // window starts out all zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xyz_reg <= '0;
        end
        else
        begin
            xyz_reg <= xyz_next;
        end
    end

    assign xyz_out = xyz_reg;

endmodule

`default_nettype wire

>>> rtl/tamad_out.sv
// ----------------------------------------------------------------------------
// tamad_out: report formatting and output skid stage
// Floors the sums to averages, checks the dead zone, buffers two results.
// ----------------------------------------------------------------------------
`default_nettype none

module tamad_out
    import tamad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF,
    parameter int SUM_W       = SAMPLE_BITS + WINDOW_LOG2,
    parameter int M_DATA_W    = ((3 * SAMPLE_BITS + 1 + 7) / 8) * 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire logic [SUM_W-1:0]       sum_x,
    input  wire logic [SUM_W-1:0]       sum_y,
    input  wire logic [SUM_W-1:0]       sum_z,
    input  wire logic [THRESH_BITS-1:0] thresh,
    output logic                        in_ready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_W-1:0]         m_tdata
);

    localparam int DATA_W = 3 * SAMPLE_BITS + 1;
    localparam int CMP_W  = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 2;

    logic [SAMPLE_BITS-1:0]   avg_x;
    logic [SAMPLE_BITS-1:0]   avg_y;
    logic [SAMPLE_BITS-1:0]   avg_z;
    logic signed [CMP_W-1:0]  ax_ext;
    logic signed [CMP_W-1:0]  ay_ext;
    logic signed [CMP_W-1:0]  th_pos;
    logic signed [CMP_W-1:0]  th_neg;
    logic                     moved;
    logic [DATA_W-1:0]        result;

    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_data_reg;
    logic                     skid_valid_reg;
    logic [DATA_W-1:0]        skid_data_reg;

    // floor(sum / 2^WINDOW_LOG2) is just the upper bits of the sum
    assign avg_x = sum_x[SUM_W-1 -: SAMPLE_BITS];
    assign avg_y = sum_y[SUM_W-1 -: SAMPLE_BITS];
    assign avg_z = sum_z[SUM_W-1 -: SAMPLE_BITS];

    assign ax_ext = {{(CMP_W - SAMPLE_BITS){avg_x[SAMPLE_BITS-1]}}, avg_x};
    assign ay_ext = {{(CMP_W - SAMPLE_BITS){avg_y[SAMPLE_BITS-1]}}, avg_y};
    assign th_pos = {{(CMP_W - THRESH_BITS){1'b0}}, thresh};
    assign th_neg = -th_pos;

    assign moved = (ax_ext > th_pos) || (ax_ext < th_neg) ||
                   (ay_ext > th_pos) || (ay_ext < th_neg);

    assign result = {moved, avg_z, avg_y, avg_x};

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_tready)
            begin
                // output slot frees up: refill from skid first, then from new push
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        if (out_valid_reg && !m_tready && push)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

endmodule

`default_nettype wire

>>> rtl/three_axis_moving_average_deadzone_unit.sv
// ----------------------------------------------------------------------------
// three_axis_moving_average_deadzone_unit: 3-axis boxcar average, dead zone
//
// Input stream (s_*): one transfer per item. s_tuser = operation
// (OP_SAMPLE pushes x/y/z into the window, OP_REPORT asks for a result).
// Output stream (m_*): one transfer per report, carrying the floored window
// averages of x, y, z and the moved flag.
// Window: a chain of 2^WINDOW_LOG2 slot cells; every sample shifts the chain
// by one, the cell dropping off the end is the oldest sample and is taken
// back out of the running sums in the same cycle.
// Throughput: one item per cycle while s_tready is high, set by the single
// add/subtract per axis on the sum registers. A report is registered in the
// output or skid register and reflects every sample accepted before it.
// Stall: a two-entry output stage (register plus skid) absorbs results; with
// both entries full s_tready drops until the receiver takes one.
// Reset: window, sums and output stage clear, move_threshold returns to 2.
// cfg_we writes move_threshold; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_moving_average_deadzone_unit
    import tamad_pkg::*;
#(
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int S_DATA_W    = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    parameter int M_DATA_W    = ((3 * SAMPLE_BITS + 1 + 7) / 8) * 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration: move_threshold
    input  wire logic                   cfg_we,
    input  wire logic [THRESH_BITS-1:0] cfg_wdata,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_W-1:0]    s_tdata,   // sample_x, sample_y, sample_z, zero pad
    input  wire logic                   s_tuser,   // operation
    // output stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_W-1:0]         m_tdata    // avg_x, avg_y, avg_z, moved, zero pad
);

    localparam int DEPTH  = 1 << WINDOW_LOG2;
    localparam int SUM_W  = SAMPLE_BITS + WINDOW_LOG2;
    localparam int XYZ_W  = 3 * SAMPLE_BITS;

    logic                   in_ready;
    logic                   s_xfer;
    logic                   sample_xfer;
    logic                   report_xfer;

    logic [THRESH_BITS-1:0] thresh_reg;
    logic [THRESH_BITS-1:0] thresh_next;

    // chain taps: tap[0] is the incoming sample, tap[DEPTH] the oldest
    logic [XYZ_W-1:0]       tap [DEPTH+1];

    logic [SAMPLE_BITS-1:0] new_x, new_y, new_z;
    logic [SAMPLE_BITS-1:0] old_x, old_y, old_z;

    logic [SUM_W-1:0]       sum_x_reg, sum_y_reg, sum_z_reg;
    logic [SUM_W-1:0]       sum_x_next, sum_y_next, sum_z_next;

    assign s_tready    = in_ready;
    assign s_xfer      = s_tvalid && in_ready;
    assign sample_xfer = s_xfer && (s_tuser == OP_SAMPLE);
    assign report_xfer = s_xfer && (s_tuser == OP_REPORT);

    // threshold register
    assign thresh_next = cfg_we ? cfg_wdata : thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    // window: shift chain of slot cells
    assign tap[0] = s_tdata[XYZ_W-1:0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tamad_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (sample_xfer),
            .xyz_in   (tap[i]),
            .xyz_out  (tap[i+1])
        );
    end

    assign new_x = tap[0][SAMPLE_BITS-1:0];
    assign new_y = tap[0][2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign new_z = tap[0][3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign old_x = tap[DEPTH][SAMPLE_BITS-1:0];
    assign old_y = tap[DEPTH][2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign old_z = tap[DEPTH][3*SAMPLE_BITS-1:2*SAMPLE_BITS];

    // running sums: add the new sample, drop the one leaving the window
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sum_z_next = sum_z_reg;
        if (sample_xfer)
        begin
            sum_x_next = sum_x_reg
                       + {{WINDOW_LOG2{new_x[SAMPLE_BITS-1]}}, new_x}
                       - {{WINDOW_LOG2{old_x[SAMPLE_BITS-1]}}, old_x};
            sum_y_next = sum_y_reg
                       + {{WINDOW_LOG2{new_y[SAMPLE_BITS-1]}}, new_y}
                       - {{WINDOW_LOG2{old_y[SAMPLE_BITS-1]}}, old_y};
            sum_z_next = sum_z_reg
                       + {{WINDOW_LOG2{new_z[SAMPLE_BITS-1]}}, new_z}
                       - {{WINDOW_LOG2{old_z[SAMPLE_BITS-1]}}, old_z};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
        end
        else
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            sum_z_reg <= sum_z_next;
        end
    end

    // report path and output buffering
    tamad_out #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_LOG2 (WINDOW_LOG2),
        .SUM_W       (SUM_W),
        .M_DATA_W    (M_DATA_W)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (report_xfer),
        .sum_x    (sum_x_reg),
        .sum_y    (sum_y_reg),
        .sum_z    (sum_z_reg),
        .thresh   (thresh_reg),
        .in_ready (in_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // back-pressure only while a result is pending
    a_ready_low_needs_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid
    ) else $error("s_tready low with no pending result");

    // a report into an empty output stage appears next cycle
    a_report_shows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (report_xfer && !m_tvalid) |=> m_tvalid
    ) else $error("report did not reach the output stage");

    // a sample never produces a result
    a_sample_silent: assert property (
        @(posedge clk) disable iff (!rst_n)
        (sample_xfer && !m_tvalid) |=> !m_tvalid
    ) else $error("sample produced an output transfer");

    // an empty window sums to zero right after reset
    a_sum_reset: assert property (
        @(posedge clk)
        !rst_n |=> (sum_x_reg == '0 && sum_y_reg == '0 && sum_z_reg == '0) || rst_n
    ) else $error("sums not cleared by reset");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for three_axis_moving_average_deadzone_unit
// A queue-fed driver pushes sample and report transfers. A scoreboard
// model keeps its own 32-deep windows, running sums and threshold.
// The monitor checks every output transfer, field by field, against the
// oldest predicted report. The threshold moves across phases, extremes
// included. Both sides idle at random, except for one stretch with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tamad_pkg::*;

    localparam int SB             = SAMPLE_BITS_DEF;
    localparam int WL             = WINDOW_LOG2_DEF;
    localparam int DEPTH          = 1 << WL;
    localparam int SUM_W          = SB + WL;
    localparam int S_W            = ((3 * SB + 7) / 8) * 8;
    localparam int M_W            = ((3 * SB + 1 + 7) / 8) * 8;
    localparam int SMAX           = (1 << (SB - 1)) - 1;
    localparam int SMIN           = -(1 << (SB - 1));
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int SETTLE_CYCLES  = 4;

    // one input item: operation on tuser, x/y/z plus a pad bit on tdata
    typedef struct packed {
        logic          op;
        logic          pad;
        logic [SB-1:0] x;
        logic [SB-1:0] y;
        logic [SB-1:0] z;
    } accel_cmd_t;

    typedef struct {
        logic [SB-1:0] ax;
        logic [SB-1:0] ay;
        logic [SB-1:0] az;
        logic          moved;
    } report_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [THRESH_BITS-1:0] cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_W-1:0]         m_tdata;

    three_axis_moving_average_deadzone_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // sample_x, sample_y, sample_z, pad
        .s_tuser   (s_tuser),   // operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // avg_x, avg_y, avg_z, moved, pad
    );

    always #5 clk = ~clk;

    // scoreboard model state
    logic signed [SB-1:0]    win_x [DEPTH];
    logic signed [SB-1:0]    win_y [DEPTH];
    logic signed [SB-1:0]    win_z [DEPTH];
    logic signed [SUM_W-1:0] sum_x = '0;
    logic signed [SUM_W-1:0] sum_y = '0;
    logic signed [SUM_W-1:0] sum_z = '0;
    logic [WL-1:0]           slot  = '0;
    logic [THRESH_BITS-1:0]  dead_zone = THRESH_RESET;

    accel_cmd_t  cmd_queue [$];
    report_t     expected_reports [$];
    accel_cmd_t  cur_cmd;
    bit          in_taken = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned idle_cycles = 0;
    int          errors = 0;
    int          n_samples = 0;
    int          n_reports = 0;
    int          n_moved = 0;
    int          n_settings = 1;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            win_x[i] = '0;
            win_y[i] = '0;
            win_z[i] = '0;
        end
    end

    function automatic logic outside_zone(logic signed [SB-1:0] a);
        int v;
        int th;
        v  = a;
        th = int'(dead_zone);
        return (v > th) || (v < -th);
    endfunction

    // apply one accepted item to the model; reports queue an expectation
    function automatic void model_accept(accel_cmd_t c);
        report_t                 r;
        logic signed [SUM_W-1:0] t;
        if (c.op == OP_SAMPLE)
        begin
            sum_x = sum_x + $signed(c.x) - win_x[slot];
            sum_y = sum_y + $signed(c.y) - win_y[slot];
            sum_z = sum_z + $signed(c.z) - win_z[slot];
            win_x[slot] = $signed(c.x);
            win_y[slot] = $signed(c.y);
            win_z[slot] = $signed(c.z);
            slot = slot + 1'b1;
        end
        else
        begin
            t = sum_x >>> WL;
            r.ax = t[SB-1:0];
            t = sum_y >>> WL;
            r.ay = t[SB-1:0];
            t = sum_z >>> WL;
            r.az = t[SB-1:0];
            r.moved = outside_zone(r.ax) || outside_zone(r.ay);
            expected_reports.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // calm stretch: neither side idles
    wire calm = (cycle_count >= 800) && (cycle_count < 1300);

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin : drive
        accel_cmd_t nxt;
        cycle_count++;
        m_tready <= rst_n && (calm || $urandom_range(0, 99) >= 25);
        if (rst_n && (!s_tvalid || in_taken))
        begin
            in_taken = 1'b0;
            if (cmd_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 25))
            begin
                nxt = cmd_queue.pop_front();
                cur_cmd  <= nxt;
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.pad, nxt.z, nxt.y, nxt.x};
                s_tuser  <= nxt.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // input acceptance, output monitor and watchdog on the rising edge
    always @(posedge clk)
    begin : monitor
        report_t exp_r;
        if (rst_n)
        begin
            idle_cycles++;
            if (s_tvalid && s_tready)
            begin
                model_accept(cur_cmd);
                in_taken = 1'b1;
                idle_cycles = 0;
                if (cur_cmd.op == OP_SAMPLE)
                    n_samples++;
            end
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: report with none expected, actual %h", $time, m_tdata);
                end
                else
                begin
                    exp_r = expected_reports.pop_front();
                    n_reports++;
                    if (exp_r.moved)
                        n_moved++;
                    check_field("avg_x", $signed(exp_r.ax), $signed(m_tdata[SB-1:0]));
                    check_field("avg_y", $signed(exp_r.ay), $signed(m_tdata[2*SB-1:SB]));
                    check_field("avg_z", $signed(exp_r.az), $signed(m_tdata[3*SB-1:2*SB]));
                    check_field("moved", exp_r.moved, m_tdata[3*SB]);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic accel_cmd_t mk(logic op, int x, int y, int z, logic pad);
        accel_cmd_t c;
        c.op  = op;
        c.pad = pad;
        c.x   = x[SB-1:0];
        c.y   = y[SB-1:0];
        c.z   = z[SB-1:0];
        return c;
    endfunction

    function automatic int clamp(int v);
        return (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
    endfunction

    function automatic int rnd_sample();
        return int'($urandom_range(0, 2 * SMAX + 1)) + SMIN;
    endfunction

    // block is idle: everything sent, every report back, pipeline drained
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(int v);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[THRESH_BITS-1:0];
        dead_zone = v[THRESH_BITS-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // bursts of one flavor: uniform, biased around a level, full-scale, tiny
    task automatic queue_random(int count);
        int added;
        int flavor;
        int len;
        int bx, by, bz;
        int noise;
        int rep_pct;
        int x, y, z;
        added = 0;
        while (added < count)
        begin
            flavor = $urandom_range(0, 3);
            len    = $urandom_range(8, 48);
            bx     = rnd_sample();
            by     = rnd_sample();
            bz     = rnd_sample();
            noise  = $urandom_range(0, 128);
            rep_pct = (flavor == 2) ? 12 : 25;
            if (flavor == 2)
            begin
                len = $urandom_range(34, 60);
                bx  = $urandom_range(0, 1) ? SMAX : SMIN;
                by  = $urandom_range(0, 1) ? SMAX : SMIN;
                bz  = $urandom_range(0, 1) ? SMAX : SMIN;
            end
            for (int i = 0; i < len && added < count; i++)
            begin
                case (flavor)
                    0:
                    begin
                        x = rnd_sample();
                        y = rnd_sample();
                        z = rnd_sample();
                    end
                    1:
                    begin
                        x = clamp(bx + int'($urandom_range(0, 2 * noise)) - noise);
                        y = clamp(by + int'($urandom_range(0, 2 * noise)) - noise);
                        z = clamp(bz + int'($urandom_range(0, 2 * noise)) - noise);
                    end
                    2:
                    begin
                        x = bx;
                        y = by;
                        z = bz;
                    end
                    default:
                    begin
                        x = int'($urandom_range(0, 6)) - 3;
                        y = int'($urandom_range(0, 6)) - 3;
                        z = int'($urandom_range(0, 6)) - 3;
                    end
                endcase
                if ($urandom_range(0, 99) < rep_pct)
                    cmd_queue.push_back(mk(OP_REPORT, rnd_sample(), rnd_sample(),
                                           rnd_sample(), 1'($urandom_range(0, 1))));
                else
                    cmd_queue.push_back(mk(OP_SAMPLE, x, y, z, 1'($urandom_range(0, 1))));
                added++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, threshold at its reset value
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));       // cleared windows
        cmd_queue.push_back(mk(OP_SAMPLE, SMAX, SMIN, 0, 1'b1)); // pad bit ignored
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));
        cmd_queue.push_back(mk(OP_SAMPLE, SMIN, SMAX, -1, 1'b0));
        cmd_queue.push_back(mk(OP_REPORT, SMAX, SMIN, SMAX, 1'b1)); // data ignored
        cmd_queue.push_back(mk(OP_SAMPLE, -1, -1, -1, 1'b0));    // negative floor
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));       // back-to-back
        cmd_queue.push_back(mk(OP_SAMPLE, 96, 0, 0, 1'b0));      // avg x on the edge
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));
        cmd_queue.push_back(mk(OP_SAMPLE, 32, 0, 0, 1'b0));      // just outside
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));
        cmd_queue.push_back(mk(OP_SAMPLE, -222, 0, 0, 1'b0));    // avg x = -3
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));
        cmd_queue.push_back(mk(OP_SAMPLE, 34, 0, 0, 1'b0));      // avg x = -2
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));
        cmd_queue.push_back(mk(OP_SAMPLE, 0, SMAX, SMAX, 1'b0)); // y alone moves
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));
        cmd_queue.push_back(mk(OP_SAMPLE, 0, 0, SMIN, 1'b1));    // z never moves
        cmd_queue.push_back(mk(OP_REPORT, 0, 0, 0, 1'b0));
        queue_random(ITEMS_PER_PHASE - 20);

        // threshold sweep, extremes first
        set_threshold(0);
        queue_random(ITEMS_PER_PHASE);
        set_threshold((1 << THRESH_BITS) - 1);
        queue_random(ITEMS_PER_PHASE);
        set_threshold(1);
        queue_random(ITEMS_PER_PHASE);
        set_threshold(2047);
        queue_random(ITEMS_PER_PHASE);
        for (int p = 0; p < 4; p++)
        begin
            set_threshold($urandom_range(0, 600));
            queue_random(ITEMS_PER_PHASE);
        end
        set_threshold($urandom_range(0, (1 << THRESH_BITS) - 1));
        queue_random(ITEMS_PER_PHASE);
        wait_idle();

        $display("covered %0d samples and %0d reports (%0d flagged as moved)",
                 n_samples, n_reports, n_moved);
        $display("over %0d dead-zone settings, %0d mismatches", n_settings, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> three_axis_moving_average_deadzone_unit.f
rtl/tamad_pkg.sv
rtl/tamad_cell.sv
rtl/tamad_out.sv
rtl/three_axis_moving_average_deadzone_unit.sv
tb/tb_top.sv
